/* hdl/drld_pkg.sv */
// Data-run list decoder: shared types, codes and constants.
// Used by every module of the block; no dependencies.
package drld_pkg;

    localparam int CLUS_BYTES_W        = 22;
    localparam int ADDR_W              = 64;
    localparam int PADDR_W             = 4;
    localparam int POS_W               = 3;
    localparam int WIDTH_NIBBLE_W      = 4;
    localparam int MAX_FIELD_BYTES_DEF = 8;

    localparam logic [CLUS_BYTES_W-1:0] CLUS_BYTES_RST   = 22'd4096;
    localparam logic [ADDR_W-1:0]       BASE_ADDRESS_RST = 64'd0;

    // register select, byte address 8*i
    localparam logic REG_CLUS_BYTES   = 1'b0;
    localparam logic REG_BASE_ADDRESS = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN = 2'd0,
        ST_END = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DELTA  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       list_start;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic        sparse;
        logic [63:0] start_cluster;
        logic [63:0] length_clusters;
        logic [63:0] start_byte;
        logic [63:0] size_bytes;
    } t_out_item;

    // decoded run, before scaling
    typedef struct packed {
        t_status     status;
        logic        sparse;
        logic [63:0] start_cluster;
        logic [63:0] length_clusters;
    } t_run;

    typedef struct packed {
        logic [CLUS_BYTES_W-1:0] clus_bytes;
        logic [ADDR_W-1:0]       base_address;
    } t_cfg;

endpackage

/* hdl/data_run_list_decoder.sv */
// Data-run list decoder, top level.
// Instantiates drld_cfg, drld_dec and drld_scale; depends on drld_pkg.
//
// Input channel: one run-list byte per item (i_in_valid / o_in_ready), with
// list_start marking the header byte that opens a new list. Output channel:
// one result per completed run, end-of-list header or bad header
// (o_out_valid / i_out_ready). Bytes inside a run produce no result.
// Configuration: APB-style port, cluster size at byte address 0 and
// base_address at 8 (decoded on paddr[3]); write only while the block is idle.
// Pipeline: the byte that completes a result is parsed into the parse stage
// register, then passes the partial-product and sum/output registers.
// Throughput: one byte per cycle unless the receiver stalls; the parser state
// loop updates per byte; the 64x22 scaling uses two 32x22 products per value.
// Receiver stall: results back up through the three stage registers; bytes
// keep being accepted until the parse stage holds a result that cannot move.
// Reset: parser waits for a byte with list_start; running offset is zero,
// cluster size is 4096 and base_address is zero; the pipeline is empty.
module data_run_list_decoder #(
    parameter int MAX_FIELD_BYTES = drld_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  drld_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output drld_pkg::t_out_item           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [drld_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    drld_pkg::t_cfg cfg;
    drld_pkg::t_run run;
    logic           run_valid;
    logic           run_ready;

    drld_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .i_reg_sel (paddr[3]),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg)
    );

    drld_dec #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_run_valid (run_valid),
        .i_run_ready (run_ready),
        .o_run       (run)
    );

    drld_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_run_valid (run_valid),
        .o_run_ready (run_ready),
        .i_run       (run),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/drld_cfg.sv */
// Data-run list decoder: APB-style configuration registers.
// Depends on drld_pkg.
module drld_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          i_reg_sel,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    output drld_pkg::t_cfg                o_cfg
);

    logic [drld_pkg::CLUS_BYTES_W-1:0] r_clus_bytes;
    logic [drld_pkg::ADDR_W-1:0]       r_base_address;
    logic                              wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clus_bytes   <= drld_pkg::CLUS_BYTES_RST;
            r_base_address <= drld_pkg::BASE_ADDRESS_RST;
        end else if (wr_en) begin
            if (i_reg_sel == drld_pkg::REG_BASE_ADDRESS) begin
                r_base_address <= pwdata;
            end else begin
                r_clus_bytes <= pwdata[drld_pkg::CLUS_BYTES_W-1:0];
            end
        end
    end

    always_comb begin
        if (i_reg_sel == drld_pkg::REG_BASE_ADDRESS) begin
            prdata = r_base_address;
        end else begin
            prdata = 64'(r_clus_bytes);
        end
    end

    assign o_cfg.clus_bytes   = r_clus_bytes;
    assign o_cfg.base_address = r_base_address;

endmodule

/* hdl/drld_dec.sv */
// Data-run list decoder: header/length/delta parser and running cluster offset.
// Produces one decoded run into a registered stage. Depends on drld_pkg.
module drld_dec #(
    parameter int MAX_FIELD_BYTES = drld_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  drld_pkg::t_in_item i_in_data,
    output logic               o_run_valid,
    input  logic               i_run_ready,
    output drld_pkg::t_run     o_run
);

    localparam logic [drld_pkg::WIDTH_NIBBLE_W-1:0] MAX_W =
        drld_pkg::WIDTH_NIBBLE_W'(MAX_FIELD_BYTES);

    drld_pkg::t_phase                     r_phase, n_phase;
    logic [drld_pkg::WIDTH_NIBBLE_W-1:0]  r_lw, n_lw;
    logic [drld_pkg::WIDTH_NIBBLE_W-1:0]  r_dw, n_dw;
    logic [drld_pkg::POS_W-1:0]           r_pos, n_pos;
    logic [63:0]                          r_len, n_len;
    logic [63:0]                          r_dlt, n_dlt;
    logic [63:0]                          r_offset, n_offset;
    logic                                 r_finished, n_finished;
    logic                                 r_v1, n_v1;
    drld_pkg::t_run                       r_s1, n_s1;

    logic                                 acc;
    logic                                 go;
    logic                                 emit;
    drld_pkg::t_run                       run;
    drld_pkg::t_phase                     cur_phase;
    logic [drld_pkg::WIDTH_NIBBLE_W-1:0]  hdr_lw, hdr_dw;
    logic [drld_pkg::WIDTH_NIBBLE_W-1:0]  pos_inc;
    logic [63:0]                          byte_sh;
    logic [63:0]                          len_or, dlt_or, dlt_sx, new_off;
    logic                                 sign_bit;

    assign o_in_ready = !r_v1 || i_run_ready;
    assign acc        = i_in_valid & o_in_ready;

    assign hdr_lw  = i_in_data.data_byte[3:0];
    assign hdr_dw  = i_in_data.data_byte[7:4];
    assign pos_inc = {1'b0, r_pos} + 4'd1;

    // place the byte at its little-endian position
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            byte_sh[8*k +: 8] = (r_pos == drld_pkg::POS_W'(k)) ?
                                i_in_data.data_byte : 8'h00;
        end
    end

    assign len_or = r_len | byte_sh;
    assign dlt_or = r_dlt | byte_sh;

    // sign-extend the delta from its top byte
    always_comb begin
        sign_bit = 1'b0;
        for (int k = 1; k <= 8; k++) begin
            if (r_dw == drld_pkg::WIDTH_NIBBLE_W'(k)) begin
                sign_bit = dlt_or[8*k-1];
            end
        end
        for (int k = 0; k < 8; k++) begin
            dlt_sx[8*k +: 8] = (drld_pkg::WIDTH_NIBBLE_W'(k) < r_dw) ?
                               dlt_or[8*k +: 8] : {8{sign_bit}};
        end
    end

    assign new_off = r_offset + dlt_sx;

    always_comb begin
        n_phase    = r_phase;
        n_lw       = r_lw;
        n_dw       = r_dw;
        n_pos      = r_pos;
        n_len      = r_len;
        n_dlt      = r_dlt;
        n_offset   = r_offset;
        n_finished = r_finished;
        emit       = 1'b0;
        run        = '0;
        go         = acc & (i_in_data.list_start | ~r_finished);
        cur_phase  = i_in_data.list_start ? drld_pkg::PH_HEADER : r_phase;

        if (go) begin
            if (i_in_data.list_start) begin
                n_offset   = 64'd0;
                n_finished = 1'b0;
            end
            unique case (cur_phase)
                drld_pkg::PH_LENGTH: begin
                    n_len = len_or;
                    if (pos_inc >= r_lw) begin
                        n_pos = '0;
                        if (r_dw == '0) begin
                            emit                = 1'b1;
                            run.status          = drld_pkg::ST_RUN;
                            run.sparse          = 1'b1;
                            run.start_cluster   = r_offset;
                            run.length_clusters = len_or;
                            n_phase             = drld_pkg::PH_HEADER;
                            n_len               = 64'd0;
                            n_dlt               = 64'd0;
                        end else begin
                            n_phase = drld_pkg::PH_DELTA;
                        end
                    end else begin
                        n_pos = pos_inc[drld_pkg::POS_W-1:0];
                    end
                end
                drld_pkg::PH_DELTA: begin
                    n_dlt = dlt_or;
                    if (pos_inc >= r_dw) begin
                        emit                = 1'b1;
                        run.status          = drld_pkg::ST_RUN;
                        run.sparse          = 1'b0;
                        run.start_cluster   = new_off;
                        run.length_clusters = r_len;
                        n_offset            = new_off;
                        n_phase             = drld_pkg::PH_HEADER;
                        n_pos               = '0;
                        n_len               = 64'd0;
                        n_dlt               = 64'd0;
                    end else begin
                        n_pos = pos_inc[drld_pkg::POS_W-1:0];
                    end
                end
                default: begin
                    // header byte
                    n_lw  = hdr_lw;
                    n_dw  = hdr_dw;
                    n_pos = '0;
                    n_len = 64'd0;
                    n_dlt = 64'd0;
                    if (hdr_lw == '0 && hdr_dw == '0) begin
                        n_finished = 1'b1;
                        emit       = 1'b1;
                        run.status = drld_pkg::ST_END;
                    end else if (hdr_lw > MAX_W || hdr_dw > MAX_W) begin
                        n_finished = 1'b1;
                        emit       = 1'b1;
                        run.status = drld_pkg::ST_BAD;
                    end else begin
                        n_phase = (hdr_lw != '0) ? drld_pkg::PH_LENGTH :
                                                   drld_pkg::PH_DELTA;
                    end
                end
            endcase
        end

        n_v1 = r_v1;
        n_s1 = r_s1;
        if (o_in_ready) begin
            n_v1 = go & emit;
            n_s1 = run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= drld_pkg::PH_HEADER;
            r_lw       <= '0;
            r_dw       <= '0;
            r_pos      <= '0;
            r_len      <= 64'd0;
            r_dlt      <= 64'd0;
            r_offset   <= 64'd0;
            r_finished <= 1'b1;
            r_v1       <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_lw       <= n_lw;
            r_dw       <= n_dw;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_dlt      <= n_dlt;
            r_offset   <= n_offset;
            r_finished <= n_finished;
            r_v1       <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_run_valid = r_v1;
    assign o_run       = r_s1;

endmodule

/* hdl/drld_scale.sv */
// Data-run list decoder: cluster-size scaling and volume base add.
// Partial-product stage then sum/output register stage. Depends on drld_pkg.
module drld_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  drld_pkg::t_cfg      i_cfg,
    input  logic                i_run_valid,
    output logic                o_run_ready,
    input  drld_pkg::t_run      i_run,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output drld_pkg::t_out_item o_out_data
);

    localparam int PP_W = 32 + drld_pkg::CLUS_BYTES_W;

    logic                rdy2, rdy3;
    logic                r_v2, r_v3;
    drld_pkg::t_run      r_s2;
    logic [PP_W-1:0]     r_off_lo, r_off_hi, r_len_lo, r_len_hi;
    logic [PP_W-1:0]     n_off_lo, n_off_hi, n_len_lo, n_len_hi;
    drld_pkg::t_out_item r_out, n_out;
    logic [PP_W-1:0]     cs_ext;
    logic [63:0]         off_sum, len_sum;

    assign rdy3        = !r_v3 || i_out_ready;
    assign rdy2        = !r_v2 || rdy3;
    assign o_run_ready = rdy2;

    assign cs_ext   = PP_W'(i_cfg.clus_bytes);
    assign n_off_lo = PP_W'(i_run.start_cluster[31:0]) * cs_ext;
    assign n_off_hi = PP_W'(i_run.start_cluster[63:32]) * cs_ext;
    assign n_len_lo = PP_W'(i_run.length_clusters[31:0]) * cs_ext;
    assign n_len_hi = PP_W'(i_run.length_clusters[63:32]) * cs_ext;

    // upper partial product only contributes its low 32 bits mod 2^64
    assign off_sum = {r_off_hi[31:0], 32'd0} + 64'(r_off_lo) + i_cfg.base_address;
    assign len_sum = {r_len_hi[31:0], 32'd0} + 64'(r_len_lo);

    always_comb begin
        n_out.status          = r_s2.status;
        n_out.sparse          = r_s2.sparse;
        n_out.start_cluster   = r_s2.start_cluster;
        n_out.length_clusters = r_s2.length_clusters;
        n_out.start_byte      = (r_s2.status == drld_pkg::ST_RUN) ? off_sum : 64'd0;
        n_out.size_bytes      = len_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_run_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2     <= i_run;
            r_off_lo <= n_off_lo;
            r_off_hi <= n_off_hi;
            r_len_lo <= n_len_lo;
            r_len_hi <= n_len_hi;
        end
        if (rdy3) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

endmodule
